>>> hdl/jpi_pkg.sv
// ----------------------------------------------------------------------------
// jpi_pkg
// Types and constants shared by the Jacobsen peak interpolator and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package jpi_pkg;

  localparam int BC_W      = 17;
  localparam int TS_W      = 17;
  localparam int FS_W      = 27;
  localparam int CFG_W     = 27;
  localparam int CFG_IDX_W = 2;

  localparam int STAT_W    = 3;
  localparam int FRAC_BITS = 16;
  localparam int FRAC_W    = 17;
  localparam int INTERP_W  = 32;
  localparam int FREQ_W    = 35;

  localparam int PROD_W    = INTERP_W + FS_W;
  localparam int P_W       = PROD_W + 1;
  localparam int DV_W      = TS_W + 8;

  localparam int OFFS_NUM  = 10000;
  localparam int OFFS_DEN  = 5001;
  localparam int FRAC_LIMIT = 32775;

  localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSFORM_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE    = 2'd2;

  localparam logic [BC_W-1:0] BIN_COUNT_RST      = 17'd1024;
  localparam logic [TS_W-1:0] TRANSFORM_SIZE_RST = 17'd1024;
  localparam logic [FS_W-1:0] SAMPLE_RATE_RST    = 27'd1000000;

  localparam logic [BC_W-1:0] MIN_BINS      = 17'd3;
  localparam logic [TS_W-1:0] MIN_TRANSFORM = 17'd2;

  localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};

  typedef logic [STAT_W-1:0] status_t;

  localparam status_t ST_OK         = 3'd0;
  localparam status_t ST_INSUFF     = 3'd1;
  localparam status_t ST_RANGE      = 3'd2;
  localparam status_t ST_NO_FEATURE = 3'd4;

endpackage

`default_nettype wire

>>> hdl/jacobsen_peak_interpolator.sv
// ----------------------------------------------------------------------------
// jacobsen_peak_interpolator
// Three-bin Jacobsen frequency estimator, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries the left, peak and right
//   complex bins and the coarse peak index. Result channel (out_valid /
//   out_stall) returns status, Q16 offset, Q16 interpolated bin and Q8 Hz.
//   The cfg_ port writes bin_count, transform_size and the sample rate; write
//   only while no item is in flight.
//   The pipeline has 61 register stages. One item is accepted every cycle
//   while in_stall is low; the 16-step offset divider and the 35-step
//   frequency divider each produce one quotient bit per stage.
//   Reset (rst_n low, synchronous) empties the pipeline and loads the
//   default settings. When out_stall holds a waiting result, the whole
//   pipeline freezes and in_stall rises in the same cycle; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module jacobsen_peak_interpolator
  import jpi_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 24,
  parameter int INDEX_WIDTH  = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [CFG_IDX_W-1:0]           cfg_index,
  input  wire logic [CFG_W-1:0]               cfg_wdata,
  input  wire logic                           in_valid,
  output      logic                           in_stall,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_left_re,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_left_im,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_center_re,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_center_im,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_right_re,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_right_im,
  input  wire logic [INDEX_WIDTH-1:0]         in_peak_index,
  output      logic                           out_valid,
  input  wire logic                           out_stall,
  output      logic [STAT_W-1:0]              out_status,
  output      logic signed [FRAC_W-1:0]       out_fractional_bin,
  output      logic [INTERP_W-1:0]            out_interpolated_bin,
  output      logic [FREQ_W-1:0]              out_frequency_q8
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int IW     = INDEX_WIDTH;
  localparam int SQ_W   = 2 * SW;
  localparam int PW_W   = SQ_W + 1;
  localparam int NR_W   = SW + 1;
  localparam int DR_W   = SW + 2;
  localparam int PR_W   = NR_W + DR_W;
  localparam int NUM_W  = PR_W + 1;
  localparam int DSQ_W  = 2 * DR_W;
  localparam int DEN_W  = DSQ_W + 1;
  localparam int R_W    = DEN_W + 1;
  localparam int CMP_W  = DEN_W + 14;
  localparam int PK_W   = (IW + 1 > BC_W) ? IW + 1 : BC_W;
  localparam int IP_W   = (IW + FRAC_W > INTERP_W + 1) ? IW + FRAC_W : INTERP_W + 1;
  localparam int FD_N   = FRAC_BITS;
  localparam int QD_N   = FREQ_W;

  logic [BC_W-1:0] bin_count_r;
  logic [TS_W-1:0] transform_size_r;
  logic [FS_W-1:0] sample_rate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_count_r      <= BIN_COUNT_RST;
      transform_size_r <= TRANSFORM_SIZE_RST;
      sample_rate_r    <= SAMPLE_RATE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BIN_COUNT:      bin_count_r      <= cfg_wdata[BC_W-1:0];
        REG_TRANSFORM_SIZE: transform_size_r <= cfg_wdata[TS_W-1:0];
        REG_SAMPLE_RATE:    sample_rate_r    <= cfg_wdata[FS_W-1:0];
        default: ;
      endcase
    end
  end

  logic advance;
  logic qd_v_r [QD_N+1];

  assign advance  = !(qd_v_r[QD_N] && out_stall);
  assign in_stall = !advance;

  // stage 1: capture
  logic                 s1_v_r;
  logic signed [SW-1:0] s1_lr_r, s1_li_r, s1_cr_r, s1_ci_r, s1_rr_r, s1_ri_r;
  logic [IW-1:0]        s1_pk_r;

  // stage 2: squares, differences, settings checks
  logic                   s2_v_r;
  logic [SQ_W-1:0]        s2_lrsq_r, s2_lisq_r, s2_crsq_r, s2_cisq_r, s2_rrsq_r, s2_risq_r;
  logic signed [NR_W-1:0] s2_nre_r, s2_nim_r;
  logic signed [DR_W-1:0] s2_dre_r, s2_dim_r;
  status_t                s2_stat_r;
  logic [IW-1:0]          s2_pk_r;

  logic signed [SQ_W-1:0] lrsq, lisq, crsq, cisq, rrsq, risq;
  logic signed [NR_W-1:0] nre_nxt, nim_nxt;
  logic signed [DR_W-1:0] dre_nxt, dim_nxt;
  logic [PK_W-1:0]        pk_inc;
  status_t                s2_stat_nxt;

  assign lrsq = s1_lr_r * s1_lr_r;
  assign lisq = s1_li_r * s1_li_r;
  assign crsq = s1_cr_r * s1_cr_r;
  assign cisq = s1_ci_r * s1_ci_r;
  assign rrsq = s1_rr_r * s1_rr_r;
  assign risq = s1_ri_r * s1_ri_r;

  assign nre_nxt = NR_W'(s1_lr_r) - NR_W'(s1_rr_r);
  assign nim_nxt = NR_W'(s1_li_r) - NR_W'(s1_ri_r);
  assign dre_nxt = (DR_W'(s1_cr_r) <<< 1) - DR_W'(s1_lr_r) - DR_W'(s1_rr_r);
  assign dim_nxt = (DR_W'(s1_ci_r) <<< 1) - DR_W'(s1_li_r) - DR_W'(s1_ri_r);
  assign pk_inc  = PK_W'(s1_pk_r) + PK_W'(1);

  always_comb begin
    if (bin_count_r < MIN_BINS || transform_size_r < MIN_TRANSFORM) begin
      s2_stat_nxt = ST_INSUFF;
    end else if (s1_pk_r == '0 || pk_inc >= PK_W'(bin_count_r) || sample_rate_r == '0) begin
      s2_stat_nxt = ST_RANGE;
    end else begin
      s2_stat_nxt = ST_OK;
    end
  end

  // stage 3: peak test, cross products
  logic                   s3_v_r;
  logic signed [PR_W-1:0] s3_pa_r, s3_pb_r;
  logic signed [DSQ_W-1:0] s3_da_r, s3_db_r;
  status_t                s3_stat_r;
  logic [IW-1:0]          s3_pk_r;

  logic [PW_W-1:0]         pc, pl, pr;
  logic signed [PR_W-1:0]  pa_nxt, pb_nxt;
  logic signed [DSQ_W-1:0] da_nxt, db_nxt;
  status_t                 s3_stat_nxt;

  assign pc = PW_W'(s2_crsq_r) + PW_W'(s2_cisq_r);
  assign pl = PW_W'(s2_lrsq_r) + PW_W'(s2_lisq_r);
  assign pr = PW_W'(s2_rrsq_r) + PW_W'(s2_risq_r);

  assign pa_nxt = s2_nre_r * s2_dre_r;
  assign pb_nxt = s2_nim_r * s2_dim_r;
  assign da_nxt = s2_dre_r * s2_dre_r;
  assign db_nxt = s2_dim_r * s2_dim_r;

  always_comb begin
    s3_stat_nxt = s2_stat_r;
    if (s2_stat_r == ST_OK && (pc == '0 || pc < pl || pc < pr)) begin
      s3_stat_nxt = ST_NO_FEATURE;
    end
  end

  // stage 4: numerator and denominator
  logic                    s4_v_r;
  logic signed [NUM_W-1:0] s4_num_r;
  logic [DEN_W-1:0]        s4_den_r;
  status_t                 s4_stat_r;
  logic [IW-1:0]           s4_pk_r;

  // stage 5: magnitude and scaled bound terms
  logic             s5_v_r;
  logic [NUM_W-1:0] s5_an_r;
  logic             s5_neg_r;
  logic [CMP_W-1:0] s5_a10k_r, s5_d5001_r;
  logic [DEN_W-1:0] s5_den_r;
  status_t          s5_stat_r;
  logic [IW-1:0]    s5_pk_r;

  logic [NUM_W-1:0] an_nxt;

  assign an_nxt = s4_num_r[NUM_W-1] ? NUM_W'(-s4_num_r) : NUM_W'(s4_num_r);

  // offset divider, stage 0 holds the bound check
  logic                 fd_v_r    [FD_N+1];
  logic [R_W-1:0]       fd_rem_r  [FD_N+1];
  logic [FRAC_BITS-1:0] fd_q_r    [FD_N+1];
  logic [DEN_W-1:0]     fd_den_r  [FD_N+1];
  logic                 fd_neg_r  [FD_N+1];
  status_t              fd_stat_r [FD_N+1];
  logic [IW-1:0]        fd_pk_r   [FD_N+1];

  status_t fd0_stat_nxt;

  always_comb begin
    fd0_stat_nxt = s5_stat_r;
    if (s5_stat_r == ST_OK && (s5_den_r == '0 || s5_a10k_r > s5_d5001_r)) begin
      fd0_stat_nxt = ST_NO_FEATURE;
    end
  end

  // stages 7 to 9: rounding, interpolated bin, frequency product
  logic                     s7_v_r;
  logic signed [FRAC_W-1:0] s7_frac_r;
  status_t                  s7_stat_r;
  logic [IW-1:0]            s7_pk_r;

  logic                     s8_v_r;
  logic signed [FRAC_W-1:0] s8_frac_r;
  logic [INTERP_W-1:0]      s8_interp_r;
  status_t                  s8_stat_r;

  logic                     s9_v_r;
  logic signed [FRAC_W-1:0] s9_frac_r;
  logic [INTERP_W-1:0]      s9_interp_r;
  logic [PROD_W-1:0]        s9_prod_r;
  status_t                  s9_stat_r;

  logic [R_W:0]             rem2;
  logic [FRAC_W-1:0]        q_rnd;
  logic signed [FRAC_W-1:0] frac_nxt;
  logic [IP_W-1:0]          interp_sum;

  assign rem2  = {fd_rem_r[FD_N], 1'b0};
  assign q_rnd = FRAC_W'(fd_q_r[FD_N]) + FRAC_W'(rem2 >= (R_W + 1)'(fd_den_r[FD_N]));

  always_comb begin
    if (fd_stat_r[FD_N] != ST_OK) begin
      frac_nxt = '0;
    end else if (fd_neg_r[FD_N]) begin
      frac_nxt = -$signed(q_rnd);
    end else begin
      frac_nxt = $signed(q_rnd);
    end
  end

  assign interp_sum = IP_W'({s7_pk_r, {FRAC_BITS{1'b0}}}) +
                      {{(IP_W-FRAC_W){s7_frac_r[FRAC_W-1]}}, s7_frac_r};

  // frequency divider, stage 0 holds the rounded dividend
  logic                 qd_sat_r    [QD_N+1];
  logic [DV_W:0]        qd_rem_r    [QD_N+1];
  logic [FREQ_W-1:0]    qd_low_r    [QD_N+1];
  logic [FREQ_W-1:0]    qd_q_r      [QD_N+1];
  status_t              qd_stat_r   [QD_N+1];
  logic [FRAC_W-1:0]    qd_frac_r   [QD_N+1];
  logic [INTERP_W-1:0]  qd_interp_r [QD_N+1];

  logic [P_W-1:0]  p_nxt;
  logic [DV_W-1:0] div_val;
  logic            sat_nxt;

  assign div_val = {transform_size_r, 8'd0};
  assign p_nxt   = (s9_stat_r == ST_OK) ?
                   P_W'(s9_prod_r) + P_W'({transform_size_r, 7'd0}) : '0;
  assign sat_nxt = p_nxt[P_W-1:FREQ_W] >= div_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      s3_v_r    <= 1'b0;
      s4_v_r    <= 1'b0;
      s5_v_r    <= 1'b0;
      fd_v_r[0] <= 1'b0;
      s7_v_r    <= 1'b0;
      s8_v_r    <= 1'b0;
      s9_v_r    <= 1'b0;
      qd_v_r[0] <= 1'b0;
    end else if (advance) begin
      s1_v_r    <= in_valid;
      s2_v_r    <= s1_v_r;
      s3_v_r    <= s2_v_r;
      s4_v_r    <= s3_v_r;
      s5_v_r    <= s4_v_r;
      fd_v_r[0] <= s5_v_r;
      s7_v_r    <= fd_v_r[FD_N];
      s8_v_r    <= s7_v_r;
      s9_v_r    <= s8_v_r;
      qd_v_r[0] <= s9_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_lr_r <= in_left_re;
      s1_li_r <= in_left_im;
      s1_cr_r <= in_center_re;
      s1_ci_r <= in_center_im;
      s1_rr_r <= in_right_re;
      s1_ri_r <= in_right_im;
      s1_pk_r <= in_peak_index;

      s2_lrsq_r <= lrsq;
      s2_lisq_r <= lisq;
      s2_crsq_r <= crsq;
      s2_cisq_r <= cisq;
      s2_rrsq_r <= rrsq;
      s2_risq_r <= risq;
      s2_nre_r  <= nre_nxt;
      s2_nim_r  <= nim_nxt;
      s2_dre_r  <= dre_nxt;
      s2_dim_r  <= dim_nxt;
      s2_stat_r <= s2_stat_nxt;
      s2_pk_r   <= s1_pk_r;

      s3_pa_r   <= pa_nxt;
      s3_pb_r   <= pb_nxt;
      s3_da_r   <= da_nxt;
      s3_db_r   <= db_nxt;
      s3_stat_r <= s3_stat_nxt;
      s3_pk_r   <= s2_pk_r;

      s4_num_r  <= NUM_W'(s3_pa_r) + NUM_W'(s3_pb_r);
      s4_den_r  <= DEN_W'($unsigned(s3_da_r)) + DEN_W'($unsigned(s3_db_r));
      s4_stat_r <= s3_stat_r;
      s4_pk_r   <= s3_pk_r;

      s5_an_r    <= an_nxt;
      s5_neg_r   <= s4_num_r[NUM_W-1];
      s5_a10k_r  <= CMP_W'(an_nxt) * CMP_W'(OFFS_NUM);
      s5_d5001_r <= CMP_W'(s4_den_r) * CMP_W'(OFFS_DEN);
      s5_den_r   <= s4_den_r;
      s5_stat_r  <= s4_stat_r;
      s5_pk_r    <= s4_pk_r;

      fd_rem_r[0]  <= R_W'(s5_an_r);
      fd_q_r[0]    <= '0;
      fd_den_r[0]  <= s5_den_r;
      fd_neg_r[0]  <= s5_neg_r;
      fd_stat_r[0] <= fd0_stat_nxt;
      fd_pk_r[0]   <= s5_pk_r;

      s7_frac_r <= frac_nxt;
      s7_stat_r <= fd_stat_r[FD_N];
      s7_pk_r   <= fd_pk_r[FD_N];

      s8_frac_r   <= s7_frac_r;
      s8_interp_r <= (s7_stat_r == ST_OK) ? interp_sum[INTERP_W-1:0] : '0;
      s8_stat_r   <= s7_stat_r;

      s9_frac_r   <= s8_frac_r;
      s9_interp_r <= s8_interp_r;
      s9_prod_r   <= PROD_W'(s8_interp_r) * PROD_W'(sample_rate_r);
      s9_stat_r   <= s8_stat_r;

      qd_sat_r[0]    <= sat_nxt;
      qd_rem_r[0]    <= sat_nxt ? '0 : {1'b0, p_nxt[P_W-1:FREQ_W]};
      qd_low_r[0]    <= p_nxt[FREQ_W-1:0];
      qd_q_r[0]      <= '0;
      qd_stat_r[0]   <= s9_stat_r;
      qd_frac_r[0]   <= s9_frac_r;
      qd_interp_r[0] <= s9_interp_r;
    end
  end

  for (genvar k = 1; k <= FD_N; k++) begin : g_fd
    logic [R_W-1:0] t;
    logic           ge;

    assign t  = {fd_rem_r[k-1][R_W-2:0], 1'b0};
    assign ge = t >= R_W'(fd_den_r[k-1]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        fd_v_r[k] <= 1'b0;
      end else if (advance) begin
        fd_v_r[k] <= fd_v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        fd_rem_r[k]  <= ge ? t - R_W'(fd_den_r[k-1]) : t;
        fd_q_r[k]    <= {fd_q_r[k-1][FRAC_BITS-2:0], ge};
        fd_den_r[k]  <= fd_den_r[k-1];
        fd_neg_r[k]  <= fd_neg_r[k-1];
        fd_stat_r[k] <= fd_stat_r[k-1];
        fd_pk_r[k]   <= fd_pk_r[k-1];
      end
    end
  end

  for (genvar k = 1; k <= QD_N; k++) begin : g_qd
    logic [DV_W:0] t;
    logic          ge;

    assign t  = {qd_rem_r[k-1][DV_W-1:0], qd_low_r[k-1][FREQ_W-1]};
    assign ge = t >= {1'b0, div_val};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        qd_v_r[k] <= 1'b0;
      end else if (advance) begin
        qd_v_r[k] <= qd_v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        qd_rem_r[k]    <= ge ? t - {1'b0, div_val} : t;
        qd_low_r[k]    <= {qd_low_r[k-1][FREQ_W-2:0], 1'b0};
        qd_q_r[k]      <= {qd_q_r[k-1][FREQ_W-2:0], ge};
        qd_sat_r[k]    <= qd_sat_r[k-1];
        qd_stat_r[k]   <= qd_stat_r[k-1];
        qd_frac_r[k]   <= qd_frac_r[k-1];
        qd_interp_r[k] <= qd_interp_r[k-1];
      end
    end
  end

  assign out_valid            = qd_v_r[QD_N];
  assign out_status           = qd_stat_r[QD_N];
  assign out_fractional_bin   = $signed(qd_frac_r[QD_N]);
  assign out_interpolated_bin = qd_interp_r[QD_N];
  assign out_frequency_q8     = (qd_stat_r[QD_N] != ST_OK) ? '0 :
                                qd_sat_r[QD_N] ? FREQ_MAX : qd_q_r[QD_N];

endmodule

`default_nettype wire

>>> hdl/jpi_checker.sv
// ----------------------------------------------------------------------------
// jpi_checker
// Port-level checks on the result channel of the peak interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

module jpi_checker
  import jpi_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     out_valid,
  input wire logic                     out_stall,
  input wire logic [STAT_W-1:0]        out_status,
  input wire logic signed [FRAC_W-1:0] out_fractional_bin,
  input wire logic [INTERP_W-1:0]      out_interpolated_bin,
  input wire logic [FREQ_W-1:0]        out_frequency_q8
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_INSUFF ||
                   out_status == ST_RANGE || out_status == ST_NO_FEATURE))
    else $error("unexpected status code");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |->
      out_fractional_bin == '0 && out_interpolated_bin == '0 && out_frequency_q8 == '0)
    else $error("rejected item carries nonzero result");

  a_frac_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK |->
      out_fractional_bin <= FRAC_W'(FRAC_LIMIT) && out_fractional_bin >= -FRAC_W'(FRAC_LIMIT))
    else $error("offset beyond half a bin");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_fractional_bin) && $stable(out_interpolated_bin) &&
      $stable(out_frequency_q8))
    else $error("stalled item changed");

endmodule

bind jacobsen_peak_interpolator jpi_checker u_jpi_checker (.*);

`default_nettype wire

>>> verif/jacobsen_peak_interpolator_tb.sv
// ----------------------------------------------------------------------------
// jacobsen_peak_interpolator_tb
// Self-checking bench: a directed table of peak candidates and random bins
// under several settings, each result compared with a hand-written expectation
// or with an integer Jacobsen offset and frequency computed in the bench, with
// random gaps on both sides.
`default_nettype none

module jacobsen_peak_interpolator_tb;
  import jpi_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW = 24;
  localparam int IW = 16;
  localparam int LATENCY = 61;
  localparam int WATCHDOG = 20000;
  localparam int NUM_RANDOM = 1430;
  localparam int NUM_DIRECTED = 14;

  typedef struct {
    logic signed [SW-1:0] lre, lim, cre, cim, rre, rim;
    logic [IW-1:0]        pk;
  } bins_t;

  typedef struct {
    status_t                  st;
    logic signed [FRAC_W-1:0] frac;
    logic [INTERP_W-1:0]      interp;
    logic [FREQ_W-1:0]        freq;
  } estimate_t;

  typedef struct {
    bins_t     b;
    bit        typed;
    estimate_t e;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SW-1:0] in_left_re = '0, in_left_im = '0, in_center_re = '0;
  logic signed [SW-1:0] in_center_im = '0, in_right_re = '0, in_right_im = '0;
  logic [IW-1:0] in_peak_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic signed [FRAC_W-1:0] out_fractional_bin;
  logic [INTERP_W-1:0] out_interpolated_bin;
  logic [FREQ_W-1:0] out_frequency_q8;

  logic [BC_W-1:0] bin_count;
  logic [TS_W-1:0] transform_size;
  logic [FS_W-1:0] sample_rate;

  estimate_t pending_estimates[$];
  int errors = 0;
  int idle_cycles = 0;
  bit done = 1'b0;
  row_t directed[NUM_DIRECTED];

  jacobsen_peak_interpolator uut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_stall,
    .in_left_re, .in_left_im, .in_center_re, .in_center_im,
    .in_right_re, .in_right_im, .in_peak_index,
    .out_valid, .out_stall,
    .out_status, .out_fractional_bin, .out_interpolated_bin, .out_frequency_q8
  );

  always #5 clk = ~clk;

  function automatic longint unsigned power(longint re, longint im);
    return longint'(re * re) + longint'(im * im);
  endfunction

  function automatic estimate_t estimate(bins_t b);
    estimate_t e;
    longint lr, li, cr, ci, rr, ri, dre, dim, num, frac;
    longint unsigned pc, pl, pr, den, an, rem, q, interp;
    logic [127:0] prod, dv, fq;
    e = '{ST_OK, '0, '0, '0};
    lr = b.lre; li = b.lim; cr = b.cre; ci = b.cim; rr = b.rre; ri = b.rim;
    if (bin_count < MIN_BINS || transform_size < MIN_TRANSFORM) begin
      e.st = ST_INSUFF;
    end else if (b.pk == 0 || 64'(b.pk) + 1 >= 64'(bin_count) || sample_rate == 0) begin
      e.st = ST_RANGE;
    end else begin
      pc = power(cr, ci);
      pl = power(lr, li);
      pr = power(rr, ri);
      dre = 2 * cr - lr - rr;
      dim = 2 * ci - li - ri;
      den = power(dre, dim);
      num = (lr - rr) * dre + (li - ri) * dim;
      an = num < 0 ? -num : num;
      if (pc == 0 || pc < pl || pc < pr || den == 0 ||
          128'(an) * OFFS_NUM > 128'(den) * OFFS_DEN) begin
        e.st = ST_NO_FEATURE;
      end else begin
        rem = an;
        q = 0;
        for (int k = 0; k < FRAC_BITS; k++) begin
          rem = rem << 1;
          q = q << 1;
          if (rem >= den) begin
            rem -= den;
            q |= 1;
          end
        end
        if (2 * rem >= den) q++;
        frac = num < 0 ? -longint'(q) : longint'(q);
        interp = (longint'(b.pk) * 65536 + frac) & 64'hFFFF_FFFF;
        prod = 128'(interp) * sample_rate;
        dv = 128'(transform_size) * 256;
        fq = (prod + dv / 2) / dv;
        e.frac = frac[FRAC_W-1:0];
        e.interp = interp[INTERP_W-1:0];
        e.freq = fq > 128'(FREQ_MAX) ? FREQ_MAX : fq[FREQ_W-1:0];
      end
    end
    return e;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BIN_COUNT:      bin_count = val[BC_W-1:0];
      REG_TRANSFORM_SIZE: transform_size = val[TS_W-1:0];
      REG_SAMPLE_RATE:    sample_rate = val[FS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_estimates.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic send(bins_t b, bit typed, estimate_t e);
    repeat ($urandom_range(0, 4)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_left_re <= b.lre; in_left_im <= b.lim;
    in_center_re <= b.cre; in_center_im <= b.cim;
    in_right_re <= b.rre; in_right_im <= b.rim;
    in_peak_index <= b.pk;
    do @(posedge clk); while (in_stall);
    pending_estimates.push_back(typed ? e : estimate(b));
  endtask

  function automatic logic signed [SW-1:0] rand_sample(int bits);
    logic [SW-1:0] v;
    if (bits >= SW) return SW'($urandom);
    v = SW'($urandom_range(0, (1 << bits) - 1));
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  function automatic bins_t rand_bins();
    bins_t b;
    int bits, mode;
    mode = $urandom_range(0, 9);
    bits = $urandom_range(0, 5) == 0 ? SW : $urandom_range(1, SW - 2);
    b.pk = $urandom_range(0, 7) == 0 ? IW'($urandom) : IW'($urandom_range(0, 1100));
    b.lre = rand_sample(bits); b.lim = rand_sample(bits);
    b.rre = rand_sample(bits); b.rim = rand_sample(bits);
    b.cre = rand_sample(bits); b.cim = rand_sample(bits);
    if (mode < 7 && bits < SW) begin
      // well-formed peak: center dominant, neighbors smaller
      b.cre = rand_sample(bits + 1);
      b.cre = b.cre < 0 ? b.cre - (SW'(1) << bits) : b.cre + (SW'(1) << bits);
      b.lre = b.lre >>> 1; b.lim = b.lim >>> 1;
      b.rre = b.rre >>> 1; b.rim = b.rim >>> 1;
    end
    return b;
  endfunction

  always @(posedge clk) begin
    if (!rst_n || done) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("%0t watchdog expired", $time);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    estimate_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_estimates.size() == 0) begin
        $display("%0t unexpected result status %0d", $time, out_status);
        errors++;
      end else begin
        e = pending_estimates.pop_front();
        if (out_status !== e.st || out_fractional_bin !== e.frac ||
            out_interpolated_bin !== e.interp || out_frequency_q8 !== e.freq) begin
          $display("%0t mismatch exp %0d %0d %0h %0h got %0d %0d %0h %0h",
                   $time, e.st, e.frac, e.interp, e.freq, out_status,
                   out_fractional_bin, out_interpolated_bin, out_frequency_q8);
          errors++;
        end
      end
      stall_left = $urandom_range(0, 4);
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    bins_t b;
    estimate_t z;
    z = '{ST_OK, '0, '0, '0};
    bin_count = BIN_COUNT_RST;
    transform_size = TRANSFORM_SIZE_RST;
    sample_rate = SAMPLE_RATE_RST;
    // symmetric peak at index 100: offset zero, 100 * 1e6 / 1024 Hz
    directed[0] = '{'{0, 0, 1000, 0, 0, 0, 100}, 1'b1,
                    '{ST_OK, '0, 32'd6553600, 35'(64'd25000000)}};
    directed[1] = '{'{0, 0, 1000, 0, 0, 0, 0}, 1'b1, '{ST_RANGE, '0, '0, '0}};
    directed[2] = '{'{0, 0, 1000, 0, 0, 0, 1023}, 1'b1, '{ST_RANGE, '0, '0, '0}};
    directed[3] = '{'{0, 0, 0, 0, 0, 0, 5}, 1'b1, '{ST_NO_FEATURE, '0, '0, '0}};
    directed[4] = '{'{10, 0, 5, 0, 0, 0, 5}, 1'b1, '{ST_NO_FEATURE, '0, '0, '0}};
    directed[5] = '{'{0, 0, 5, 0, 0, 9, 5}, 1'b1, '{ST_NO_FEATURE, '0, '0, '0}};
    directed[6] = '{'{7, 0, 7, 0, 7, 0, 5}, 1'b1, '{ST_NO_FEATURE, '0, '0, '0}};
    directed[7] = '{'{-8388608, -8388608, -8388608, -8388608, 8388607, 8388607, 1021},
                    1'b0, z};
    directed[8] = '{'{8388607, 8388607, -8388608, -8388608, 8388607, -8388608, 1},
                    1'b0, z};
    directed[9] = '{'{500, 0, 1000, 0, 0, 0, 200}, 1'b0, z};
    directed[10] = '{'{0, 0, 1000, 0, 500, 0, 200}, 1'b0, z};
    directed[11] = '{'{999, 0, 1000, 0, -999, 0, 300}, 1'b0, z};
    directed[12] = '{'{0, 300, 0, -1000, 0, 700, 65535}, 1'b1, '{ST_RANGE, '0, '0, '0}};
    directed[13] = '{'{-4000, 3000, 8000, -6000, 1000, 2000, 512}, 1'b0, z};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send(directed[i].b, directed[i].typed, directed[i].e);
    in_valid <= 1'b0;
    drain();

    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_BIN_COUNT, 2); write_reg(REG_TRANSFORM_SIZE, 1024);
          write_reg(REG_SAMPLE_RATE, 1000000);
        end
        1: begin
          write_reg(REG_BIN_COUNT, 65536); write_reg(REG_TRANSFORM_SIZE, 1);
        end
        2: begin
          write_reg(REG_TRANSFORM_SIZE, 2); write_reg(REG_SAMPLE_RATE, 27'h7FFFFFF);
        end
        3: write_reg(REG_SAMPLE_RATE, 0);
        4: begin
          write_reg(REG_BIN_COUNT, 3); write_reg(REG_TRANSFORM_SIZE, 65536);
          write_reg(REG_SAMPLE_RATE, 100000000);
        end
        5: begin
          write_reg(REG_BIN_COUNT, 1024); write_reg(REG_TRANSFORM_SIZE, 1000);
          write_reg(REG_SAMPLE_RATE, 48000);
        end
        default: begin
          write_reg(REG_BIN_COUNT, $urandom_range(0, 65536));
          write_reg(REG_TRANSFORM_SIZE, $urandom_range(0, 65536));
          write_reg(REG_SAMPLE_RATE, $urandom_range(0, 100000000));
        end
      endcase
      for (int n = 0; n < (phase == 5 ? NUM_RANDOM - 6 * 40 : 40); n++) begin
        b = rand_bins();
        if (phase == 4 && n % 2 == 0) b.pk = 1;
        send(b, 1'b0, z);
        if (n == 20) begin
          in_valid <= 1'b0;
          while (pending_estimates.size() != 0) @(posedge clk);
        end
      end
      in_valid <= 1'b0;
      drain();
    end

    done = 1'b1;
    if (errors == 0 && pending_estimates.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
